// File: rtl/tbps_pkg.sv
// shared types and constants for the two-body phase space generator
// holds the cordic arctangent table, error codes and fixed-point constants
// no dependencies
package tbps_pkg;

	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic [28:0]        EIGHT_PI_Q24 = 29'd421657428;
	localparam logic signed [31:0] SAT_MAX      = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SAT_MIN      = 32'sh80000000;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_KALLEN    = 2'd1,
		ERR_ZERO_MASS = 2'd2
	} err_code_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// arctangent of 2^-i in turns scaled by 2^32
	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/tbps_delay.sv
// fixed-length register delay line for pipeline alignment
// no package dependencies
module tbps_delay #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

// File: rtl/tbps_isqrt.sv
// pipelined integer square root, one result bit per register stage
// no package dependencies
module tbps_isqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [2*W-1:0] rad,
	output logic [W-1:0]   root
);

	logic [W:0]     rem_s  [0:W-1];
	logic [W-1:0]   root_s [0:W];
	logic [2*W-1:0] rad_s  [0:W-1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [W+2:0] rem_n;
		logic [W+2:0] trial;
		logic [W+2:0] diff;
		logic         take;

		assign rem_n = {rem_s[g], rad_s[g][2*W-1 -: 2]};
		assign trial = {1'b0, root_s[g], 2'b01};
		assign diff  = rem_n - trial;
		assign take  = (rem_n >= trial);

		always_ff @(posedge clk) begin
			root_s[g+1] <= {root_s[g][W-2:0], take};
		end

		if (g < W-1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[g+1] <= take ? diff[W:0] : rem_n[W:0];
				rad_s[g+1] <= {rad_s[g][2*W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[W];

endmodule

// File: rtl/tbps_div.sv
// pipelined restoring divider, one quotient bit per register stage
// caller supplies a partial remainder already below the divisor
module tbps_div #(
	parameter int QW = 32,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] low_in,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [0:QW-1];
	logic [QW-1:0] low_s [0:QW-1];
	logic [DW-1:0] den_s [0:QW-1];
	logic [QW-1:0] quo_s [0:QW];

	assign rem_s[0] = rem_in;
	assign low_s[0] = low_in;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        take;

		assign trial = {rem_s[g], low_s[g][QW-1]};
		assign diff  = trial - {1'b0, den_s[g]};
		assign take  = (trial >= {1'b0, den_s[g]});

		always_ff @(posedge clk) begin
			quo_s[g+1] <= {quo_s[g][QW-2:0], take};
		end

		if (g < QW-1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[g+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
				low_s[g+1] <= {low_s[g][QW-2:0], 1'b0};
				den_s[g+1] <= den_s[g];
			end
		end
	end

	assign quo = quo_s[QW];

endmodule

// File: rtl/tbps_cordic.sv
// pipelined rotation cordic giving sine and cosine of an angle in turns
// depends on tbps_pkg for the arctangent table and gain
module tbps_cordic #(
	parameter int STAGES = 24
) (
	input  logic               clk,
	input  logic [31:0]        turns,
	output logic signed [33:0] sine,
	output logic signed [33:0] cosine
);
	import tbps_pkg::*;

	logic signed [33:0] x_s    [0:STAGES];
	logic signed [33:0] y_s    [0:STAGES];
	logic signed [33:0] z_s    [0:STAGES-1];
	quad_t              quad_s [0:STAGES];

	assign x_s[0]    = CORDIC_GAIN;
	assign y_s[0]    = '0;
	assign z_s[0]    = $signed({4'b0000, turns[29:0]});
	assign quad_s[0] = quad_t'(turns[31:30]);

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] at;

		assign dx = x_s[g] >>> g;
		assign dy = y_s[g] >>> g;
		assign at = $signed({2'b00, atan_turn(g)});

		always_ff @(posedge clk) begin
			quad_s[g+1] <= quad_s[g];
			if (!z_s[g][33]) begin
				x_s[g+1] <= x_s[g] - dy;
				y_s[g+1] <= y_s[g] + dx;
			end else begin
				x_s[g+1] <= x_s[g] + dy;
				y_s[g+1] <= y_s[g] - dx;
			end
		end

		if (g < STAGES-1) begin : g_ang
			always_ff @(posedge clk) begin
				z_s[g+1] <= z_s[g][33] ? (z_s[g] + at) : (z_s[g] - at);
			end
		end
	end

	// quadrant fold from the top two angle bits
	always_ff @(posedge clk) begin
		case (quad_s[STAGES])
			QUAD_1: begin
				cosine <= -y_s[STAGES];
				sine   <= x_s[STAGES];
			end
			QUAD_2: begin
				cosine <= -x_s[STAGES];
				sine   <= -y_s[STAGES];
			end
			QUAD_3: begin
				cosine <= y_s[STAGES];
				sine   <= -x_s[STAGES];
			end
			default: begin
				cosine <= x_s[STAGES];
				sine   <= y_s[STAGES];
			end
		endcase
	end

endmodule

// File: rtl/two_body_phase_space_generator_core.sv
// two-body phase space generator, one transaction accepted per cycle, busy
// stays low; the latency is set by the 62-stage divider of the kallen quotient,
// its 31-stage root and the 28-stage weight divider in series. async reset
// clears the valid pipeline and sets the tolerance register to 1. depends on
// tbps_pkg, tbps_div, tbps_isqrt, tbps_cordic and tbps_delay
module two_body_phase_space_generator_core #(
	parameter int ANGLE_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic [31:0]        mass_sq_total,
	input  logic [31:0]        mass_sq_first,
	input  logic [31:0]        mass_sq_second,
	input  logic [31:0]        polar_fraction,
	input  logic [31:0]        azimuth_fraction,
	output logic signed [31:0] energy_first,
	output logic signed [31:0] mom_x_first,
	output logic signed [31:0] mom_y_first,
	output logic signed [31:0] mom_z_first,
	output logic signed [31:0] energy_second,
	output logic signed [31:0] mom_x_second,
	output logic signed [31:0] mom_y_second,
	output logic signed [31:0] mom_z_second,
	output logic [31:0]        weight,
	output logic [1:0]         error_code
);
	import tbps_pkg::*;

	localparam int QP_W      = 62;
	localparam int P_W       = 31;
	localparam int R_W       = 32;
	localparam int E_QW      = 32;
	localparam int T_QW      = 28;
	localparam int ST_K      = 3;
	localparam int ST_DIVP   = 4;
	localparam int ST_PROOT  = ST_DIVP + QP_W + P_W;
	localparam int ST_P      = ST_PROOT + 1;
	localparam int ST_R      = 1 + R_W;
	localparam int ST_E_IN   = ST_R + 1;
	localparam int ST_E_Q    = ST_E_IN + E_QW;
	localparam int ST_E      = ST_E_Q + 1;
	localparam int ST_PT     = ST_P + 1;
	localparam int ST_PXY    = ST_PT + 1;
	localparam int ST_T_Q    = ST_PT + T_QW;
	localparam int ST_W      = ST_T_Q + 1;
	localparam int ST_OUT    = ST_W + 1;
	localparam int ST_CS     = ANGLE_STAGES + 1;

	function automatic logic signed [31:0] energy_sat(input logic [31:0] q, input logic over,
			input logic neg);
		logic signed [31:0] v;
		if (!neg) begin
			v = (over || q[31]) ? SAT_MAX : $signed(q);
		end else begin
			v = (over || q > 32'h80000000) ? SAT_MIN : $signed(32'd0 - q);
		end
		return v;
	endfunction

	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) r = SAT_MAX;
		else if (v < -36'sd2147483648) r = SAT_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		return (v == SAT_MIN) ? SAT_MAX : -v;
	endfunction

	logic [31:0]         tol_q;
	logic [ST_OUT-1:0]   vld_q;

	// stage 1
	logic [31:0] a_s1, v2_s1;
	logic        zero_s1;
	logic [33:0] absd_s1, emag1_s1, emag2_s1;
	logic        eneg1_s1, eneg2_s1;
	logic [63:0] bc_s1, sprod_s1;
	// stage 2, 3, 4
	logic [31:0] a_s2, a_s3, a_s4;
	logic        zero_s2;
	logic [67:0] sq_s2, k_s3;
	logic [65:0] fbc_s2;
	err_code_t   code_s3;
	logic [31:0] prem_s4;
	logic [61:0] plow_s4;
	logic        psat_s4;

	logic [QP_W-1:0] qp;
	logic [P_W-1:0]  proot;
	logic [R_W-1:0]  r_out, sth_out;
	logic            psat_d;

	// energy path
	logic [69:0]  emag_d;
	logic [31:0]  r_s34, erem1_s34, erem2_s34, elow1_s34, elow2_s34;
	logic         eover1_s34, eover2_s34, eneg1_s34, eneg2_s34;
	logic [31:0]  eq1, eq2;
	logic [3:0]   eflag_d;
	logic signed [31:0] e1_s67, e2_s67;
	logic [63:0]  e_d;

	// momentum and weight path
	logic [31:0]  r_d, sth_d, v2_d;
	logic [30:0]  p_s98;
	logic [30:0]  pt_s99;
	logic signed [31:0] pz_s99, pz_s100, px_s100, py_s100;
	logic [31:0]  trem_s99, r_s99;
	logic         tover_s99;
	logic signed [33:0] sin_c, cos_c;
	logic [67:0]  sc_d;
	logic [95:0]  mom_d;
	logic [T_QW-1:0] tq;
	logic         tover_d;
	logic [56:0]  wprod_s128;
	logic         wover_s128;
	logic [1:0]   code_d;

	assign busy = 1'b0;
	assign done = vld_q[ST_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 32'd1;
			vld_q <= '0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;
			vld_q <= {vld_q[ST_OUT-2:0], start};
		end
	end

	// stage 0 to 1: differences, b*c, sin^2 theta product
	always_ff @(posedge clk) begin
		logic signed [34:0] dsum, n1, n2;
		dsum = $signed({3'b000, mass_sq_total}) - $signed({3'b000, mass_sq_first})
			- $signed({3'b000, mass_sq_second});
		n1 = $signed({3'b000, mass_sq_total}) + $signed({3'b000, mass_sq_first})
			- $signed({3'b000, mass_sq_second});
		n2 = $signed({3'b000, mass_sq_total}) + $signed({3'b000, mass_sq_second})
			- $signed({3'b000, mass_sq_first});
		a_s1     <= mass_sq_total;
		zero_s1  <= (mass_sq_total == 32'd0);
		v2_s1    <= polar_fraction;
		absd_s1  <= dsum[34] ? 34'(-dsum) : dsum[33:0];
		emag1_s1 <= n1[34] ? 34'(-n1) : n1[33:0];
		eneg1_s1 <= n1[34];
		emag2_s1 <= n2[34] ? 34'(-n2) : n2[33:0];
		eneg2_s1 <= n2[34];
		bc_s1    <= {32'd0, mass_sq_first} * {32'd0, mass_sq_second};
		sprod_s1 <= {32'd0, polar_fraction} * {32'd0, 32'd0 - polar_fraction};
	end

	// stage 1 to 2: (a-b-c)^2 from a 32x32 product and small cross terms
	always_ff @(posedge clk) begin
		logic [63:0] dl2;
		logic [33:0] dlh;
		logic [3:0]  dh2;
		dl2 = {32'd0, absd_s1[31:0]} * {32'd0, absd_s1[31:0]};
		dlh = {2'b00, absd_s1[31:0]} * {32'd0, absd_s1[33:32]};
		dh2 = {2'b00, absd_s1[33:32]} * {2'b00, absd_s1[33:32]};
		sq_s2   <= {4'd0, dl2} + ({34'd0, dlh} << 33) + ({64'd0, dh2} << 64);
		fbc_s2  <= {bc_s1, 2'b00};
		a_s2    <= a_s1;
		zero_s2 <= zero_s1;
	end

	// stage 2 to 3: kallen value with clamp of small negatives
	always_ff @(posedge clk) begin
		logic signed [68:0] kd;
		logic [68:0]        mneg;
		logic               bad;
		kd   = $signed({1'b0, sq_s2}) - $signed({3'b000, fbc_s2});
		mneg = 69'(-kd);
		bad  = kd[68] && (mneg > {37'd0, tol_q});
		k_s3 <= kd[68] ? 68'd0 : kd[67:0];
		a_s3 <= a_s2;
		if (zero_s2) code_s3 <= ERR_ZERO_MASS;
		else if (bad) code_s3 <= ERR_KALLEN;
		else code_s3 <= ERR_NONE;
	end

	// stage 3 to 4: overflow test of K*2^22/a against 2^62
	always_ff @(posedge clk) begin
		logic sat;
		sat = ({4'd0, k_s3[67:40]} >= a_s3);
		psat_s4 <= sat;
		prem_s4 <= sat ? 32'd0 : {4'd0, k_s3[67:40]};
		plow_s4 <= {k_s3[39:0], 22'd0};
		a_s4    <= a_s3;
	end

	tbps_div #(.QW(QP_W), .DW(32)) u_div_p (
		.clk(clk), .rem_in(prem_s4), .low_in(plow_s4), .den(a_s4), .quo(qp)
	);

	tbps_isqrt #(.W(P_W)) u_sqrt_p (.clk(clk), .rad(qp), .root(proot));

	tbps_delay #(.WIDTH(1), .DEPTH(ST_PROOT - ST_DIVP)) u_dly_psat (
		.clk(clk), .din(psat_s4), .dout(psat_d)
	);

	tbps_isqrt #(.W(R_W)) u_sqrt_r (.clk(clk), .rad({a_s1, 32'd0}), .root(r_out));

	tbps_isqrt #(.W(R_W)) u_sqrt_sth (.clk(clk), .rad(sprod_s1), .root(sth_out));

	// energies: (num << 27) / r
	tbps_delay #(.WIDTH(70), .DEPTH(ST_R - 1)) u_dly_emag (
		.clk(clk), .din({eneg1_s1, emag1_s1, eneg2_s1, emag2_s1}), .dout(emag_d)
	);

	always_ff @(posedge clk) begin
		logic ov1, ov2;
		ov1 = ({3'b000, emag_d[68:40]} >= r_out);
		ov2 = ({3'b000, emag_d[33:5]} >= r_out);
		r_s34      <= r_out;
		eover1_s34 <= ov1;
		eover2_s34 <= ov2;
		eneg1_s34  <= emag_d[69];
		eneg2_s34  <= emag_d[34];
		erem1_s34  <= ov1 ? 32'd0 : {3'b000, emag_d[68:40]};
		erem2_s34  <= ov2 ? 32'd0 : {3'b000, emag_d[33:5]};
		elow1_s34  <= {emag_d[39:35], 27'd0};
		elow2_s34  <= {emag_d[4:0], 27'd0};
	end

	tbps_div #(.QW(E_QW), .DW(32)) u_div_e1 (
		.clk(clk), .rem_in(erem1_s34), .low_in(elow1_s34), .den(r_s34), .quo(eq1)
	);

	tbps_div #(.QW(E_QW), .DW(32)) u_div_e2 (
		.clk(clk), .rem_in(erem2_s34), .low_in(elow2_s34), .den(r_s34), .quo(eq2)
	);

	tbps_delay #(.WIDTH(4), .DEPTH(ST_E_Q - ST_E_IN)) u_dly_eflag (
		.clk(clk), .din({eover1_s34, eneg1_s34, eover2_s34, eneg2_s34}), .dout(eflag_d)
	);

	always_ff @(posedge clk) begin
		e1_s67 <= energy_sat(eq1, eflag_d[3], eflag_d[2]);
		e2_s67 <= energy_sat(eq2, eflag_d[1], eflag_d[0]);
	end

	tbps_delay #(.WIDTH(64), .DEPTH(ST_W - ST_E)) u_dly_e (
		.clk(clk), .din({e1_s67, e2_s67}), .dout(e_d)
	);

	// operands for the momentum stages
	tbps_delay #(.WIDTH(64), .DEPTH(ST_P - ST_R)) u_dly_rsth (
		.clk(clk), .din({r_out, sth_out}), .dout({r_d, sth_d})
	);

	tbps_delay #(.WIDTH(32), .DEPTH(ST_P - 1)) u_dly_v2 (
		.clk(clk), .din(v2_s1), .dout(v2_d)
	);

	tbps_cordic #(.STAGES(ANGLE_STAGES)) u_cordic (
		.clk(clk), .turns(azimuth_fraction), .sine(sin_c), .cosine(cos_c)
	);

	tbps_delay #(.WIDTH(68), .DEPTH(ST_PT - ST_CS)) u_dly_sc (
		.clk(clk), .din({sin_c, cos_c}), .dout(sc_d)
	);

	always_ff @(posedge clk) begin
		p_s98 <= psat_d ? 31'h7FFFFFFF : proot;
	end

	// stage 98 to 99: p*sin(theta), p*cos(theta), weight divider setup
	always_ff @(posedge clk) begin
		logic [62:0]        ptprod;
		logic signed [63:0] pzprod;
		logic signed [31:0] cth;
		logic               ov;
		ptprod = {32'd0, p_s98} * {31'd0, sth_d};
		cth    = $signed({~v2_d[31], v2_d[30:0]});
		pzprod = $signed({1'b0, p_s98}) * cth;
		ov     = ({p_s98, 4'b0000} >= {3'b000, r_d});
		pt_s99    <= ptprod[61:31];
		pz_s99    <= pzprod[62:31];
		tover_s99 <= ov;
		trem_s99  <= ov ? 32'd0 : {p_s98[27:0], 4'b0000};
		r_s99     <= r_d;
	end

	// stage 99 to 100: transverse components
	always_ff @(posedge clk) begin
		logic signed [65:0] pxprod, pyprod;
		pxprod = $signed({1'b0, pt_s99}) * $signed(sc_d[67:34]);
		pyprod = $signed({1'b0, pt_s99}) * $signed(sc_d[33:0]);
		px_s100 <= sat36(pxprod[65:30]);
		py_s100 <= sat36(pyprod[65:30]);
		pz_s100 <= pz_s99;
	end

	tbps_delay #(.WIDTH(96), .DEPTH(ST_W - ST_PXY)) u_dly_mom (
		.clk(clk), .din({px_s100, py_s100, pz_s100}), .dout(mom_d)
	);

	tbps_div #(.QW(T_QW), .DW(32)) u_div_t (
		.clk(clk), .rem_in(trem_s99), .low_in('0), .den(r_s99), .quo(tq)
	);

	tbps_delay #(.WIDTH(1), .DEPTH(ST_T_Q - ST_PT)) u_dly_tover (
		.clk(clk), .din(tover_s99), .dout(tover_d)
	);

	always_ff @(posedge clk) begin
		wprod_s128 <= {29'd0, tq} * {28'd0, EIGHT_PI_Q24};
		wover_s128 <= tover_d;
	end

	tbps_delay #(.WIDTH(2), .DEPTH(ST_W - ST_K)) u_dly_code (
		.clk(clk), .din(code_s3), .dout(code_d)
	);

	// output register, error transactions carry only the code
	always_ff @(posedge clk) begin
		logic ok;
		ok = (err_code_t'(code_d) == ERR_NONE);
		error_code <= code_d;
		if (ok) begin
			energy_first  <= $signed(e_d[63:32]);
			energy_second <= $signed(e_d[31:0]);
			mom_x_first   <= $signed(mom_d[95:64]);
			mom_y_first   <= $signed(mom_d[63:32]);
			mom_z_first   <= $signed(mom_d[31:0]);
			mom_x_second  <= neg_sat($signed(mom_d[95:64]));
			mom_y_second  <= neg_sat($signed(mom_d[63:32]));
			mom_z_second  <= neg_sat($signed(mom_d[31:0]));
			weight        <= (wover_s128 || wprod_s128[56]) ? 32'hFFFFFFFF : wprod_s128[55:24];
		end else begin
			energy_first  <= '0;
			energy_second <= '0;
			mom_x_first   <= '0;
			mom_y_first   <= '0;
			mom_z_first   <= '0;
			mom_x_second  <= '0;
			mom_y_second  <= '0;
			mom_z_second  <= '0;
			weight        <= '0;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##ST_OUT done)
		else $error("transaction did not complete at the pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ST_OUT))
		else $error("result without a matching transaction");

	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error_code != ERR_NONE) |->
			(weight == 32'd0 && energy_first == 32'sd0 && mom_z_first == 32'sd0))
		else $error("error result carries payload");

	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((mom_x_first == SAT_MIN && mom_x_second == SAT_MAX) ||
			(mom_x_first != SAT_MIN && mom_x_second == -mom_x_first)))
		else $error("daughter momenta not opposite");

endmodule
